FILE: sv/rwdd_pkg.sv
// Package with shared types and constants for the random word to decimal digits block.
package rwdd_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned COUNT_W = 20;
    localparam int unsigned DIGIT_W = 4;
    localparam int unsigned VALUE_W = 30;
    localparam int unsigned WIDE_W  = 34;
    localparam int unsigned STEP_W  = 4;

    localparam logic [WORD_W-1:0]  REJECT_LIMIT  = 32'd4000000000;
    localparam logic [WIDE_W-1:0]  GROUP_MODULUS = 34'd1000000000;
    localparam logic [COUNT_W-1:0] COUNT_RESET   = 20'd10;
    localparam logic [COUNT_W-1:0] GROUP_DIGITS  = 20'd9;
    localparam logic [STEP_W-1:0]  LAST_STEP     = 4'd9;
    localparam logic [STEP_W-1:0]  STEP_SPAN     = 4'd10;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Control from the sequencer to the datapath for one cycle.
    typedef struct packed {
        logic load;
        logic advance;
        logic first;
        logic emit;
        logic last;
        logic run_done;
    } seq_ctrl_t;

    // Multiple of the group modulus for a quotient digit of 0 to 9.
    function automatic logic [WIDE_W-1:0] modulus_times(input logic [DIGIT_W-1:0] q);
        logic [WIDE_W-1:0] m;
        case (q)
            4'd1:    m = 34'd1000000000;
            4'd2:    m = 34'd2000000000;
            4'd3:    m = 34'd3000000000;
            4'd4:    m = 34'd4000000000;
            4'd5:    m = 34'd5000000000;
            4'd6:    m = 34'd6000000000;
            4'd7:    m = 34'd7000000000;
            4'd8:    m = 34'd8000000000;
            4'd9:    m = 34'd9000000000;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: sv/rwdd_digit_unit.sv
// Shared step unit: one modulus reduction or one decimal digit per use.
module rwdd_digit_unit (
    input  logic                           first,
    input  logic [rwdd_pkg::WORD_W-1:0]    value,
    output logic [rwdd_pkg::DIGIT_W-1:0]   quotient,
    output logic [rwdd_pkg::VALUE_W-1:0]   remainder
);
    import rwdd_pkg::*;

    logic [WIDE_W-1:0] scaled;
    logic [WIDE_W-1:0] residue;

    // The first use reduces the raw word; later uses shift the value one
    // decimal place up so the next digit lands in the top position.
    always_comb
    begin
        if (first)
        begin
            scaled = {2'b00, value};
        end
        else
        begin
            scaled = {1'b0, value[VALUE_W-1:0], 3'b000} + {3'b000, value[VALUE_W-1:0], 1'b0};
        end
    end

    // The scaled value is below ten times the modulus, so the quotient is
    // the number of constant multiples it reaches.
    always_comb
    begin
        quotient = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (scaled >= modulus_times(DIGIT_W'(k)))
            begin
                quotient = DIGIT_W'(k);
            end
        end
    end

    assign residue   = scaled - modulus_times(quotient);
    assign remainder = residue[VALUE_W-1:0];

endmodule

FILE: sv/rwdd_sequencer.sv
// Sequencer: run counter, group length and step count for each accepted word.
module rwdd_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [rwdd_pkg::COUNT_W-1:0]  cfg_count,
    input  logic                          in_transfer,
    input  logic [rwdd_pkg::WORD_W-1:0]   word,
    input  logic                          out_free,
    output logic                          idle,
    output rwdd_pkg::seq_ctrl_t           ctrl
);
    import rwdd_pkg::*;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] remaining_reg, remaining_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [STEP_W-1:0]  len_reg, len_next;
    logic               ends_reg, ends_next;
    logic [STEP_W-1:0]  len_take;
    logic [COUNT_W-1:0] remaining_after;
    logic               usable;
    logic [STEP_W-1:0]  first_emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            remaining_reg <= COUNT_RESET;
            step_reg      <= '0;
            len_reg       <= '0;
            ends_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            remaining_reg <= remaining_next;
            step_reg      <= step_next;
            len_reg       <= len_next;
            ends_reg      <= ends_next;
        end
    end

    assign len_take        = (remaining_reg >= GROUP_DIGITS) ? GROUP_DIGITS[STEP_W-1:0]
                                                             : remaining_reg[STEP_W-1:0];
    assign remaining_after = remaining_reg - COUNT_W'(len_take);
    assign usable          = (remaining_reg != '0) && (word < REJECT_LIMIT);
    assign first_emit      = STEP_SPAN - len_reg;

    always_comb
    begin
        state_next     = state_reg;
        remaining_next = remaining_reg;
        step_next      = step_reg;
        len_next       = len_reg;
        ends_next      = ends_reg;
        idle           = 1'b0;
        ctrl           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                idle = 1'b1;
                if (in_transfer && usable)
                begin
                    ctrl.load      = 1'b1;
                    state_next     = ST_RUN;
                    step_next      = '0;
                    len_next       = len_take;
                    remaining_next = remaining_after;
                    ends_next      = (remaining_after == '0);
                end
            end
            ST_RUN:
            begin
                ctrl.advance  = out_free;
                ctrl.first    = (step_reg == '0);
                ctrl.emit     = (step_reg != '0) && (step_reg >= first_emit);
                ctrl.last     = (step_reg == LAST_STEP);
                ctrl.run_done = (step_reg == LAST_STEP) && ends_reg;
                if (out_free)
                begin
                    if (step_reg == LAST_STEP)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_write)
        begin
            remaining_next = cfg_count;
        end
    end

endmodule

FILE: sv/random_word_to_decimal_digits.sv
// Top level of the random word to decimal digits converter.
//
//  Channel  Signals                      Direction  Contents
//  s        s_tvalid s_tready s_tdata    in         random_word[31:0]
//  m        m_tvalid m_tready m_tdata    out        digit[3:0], zero padded to 8 bits
//           m_tlast m_tuser                         tlast = group_last, tuser = run_done
//  cfg      cfg_valid cfg_ready cfg_data in         digit_count[19:0]
//
// An accepted word that yields digits passes through the shared step unit: a
// first step reduces it modulo one billion and digit steps then produce its
// nine digits, most significant first; leading positions beyond the remaining
// count are computed but not transferred. After such a word is taken, s_tready
// stays low until its last step is done. A word that is rejected, or that
// arrives after the run has finished, is consumed in its transfer cycle. Each
// step waits while the output register holds a digit that has not been taken,
// so output stalls stretch the step sequence one for one. Reset loads the digit
// count of ten and needs no clearing pass; cfg_ready is always high.
module random_word_to_decimal_digits (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream. Fields from bit 0: random_word[31:0].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // Output stream. tdata fields from bit 0: digit[3:0], zeros above.
    // tuser fields from bit 0: run_done.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    output logic        m_tuser,
    // Configuration write channel. Fields from bit 0: digit_count[19:0].
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data
);
    import rwdd_pkg::*;

    seq_ctrl_t          ctrl;
    logic               idle;
    logic               in_transfer;
    logic               out_free;
    logic [WORD_W-1:0]  value_reg;
    logic [DIGIT_W-1:0] quotient;
    logic [VALUE_W-1:0] remainder;
    logic               out_valid_reg;
    logic [DIGIT_W-1:0] digit_reg;
    logic               last_reg;
    logic               done_reg;

    assign cfg_ready   = 1'b1;
    assign s_tready    = idle;
    assign in_transfer = s_tvalid && s_tready;

    // The output register may be refilled in the same cycle its digit leaves.
    assign out_free    = !out_valid_reg || m_tready;

    rwdd_sequencer u_sequencer (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_count   (cfg_data),
        .in_transfer (in_transfer),
        .word        (s_tdata),
        .out_free    (out_free),
        .idle        (idle),
        .ctrl        (ctrl)
    );

    rwdd_digit_unit u_digit_unit (
        .first     (ctrl.first),
        .value     (value_reg),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // Working value: the raw word at load, then the running remainder.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            value_reg <= s_tdata;
        end
        else if (ctrl.advance)
        begin
            value_reg <= {2'b00, remainder};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.advance && ctrl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // On the reduction step the quotient is the discarded billions count, so
    // only digit steps load the output payload.
    always_ff @(posedge clk)
    begin
        if (ctrl.advance && ctrl.emit)
        begin
            digit_reg <= quotient;
            last_reg  <= ctrl.last;
            done_reg  <= ctrl.run_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, digit_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

endmodule

FILE: tb/sv/rwdd_digit_checker.sv
// Checker that predicts and compares the digit stream of the random word to decimal digits block.
`timescale 1ns / 1ps

module rwdd_digit_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [31:0]                   s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [7:0]                    m_tdata,
    input  logic                          m_tlast,
    input  logic                          m_tuser,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [19:0]                   cfg_data,
    output int                            fail_count,
    output int                            digits_owed,
    output logic [rwdd_pkg::COUNT_W-1:0]  run_left,
    output int                            digits_matched,
    output int                            words_taken
);
    import rwdd_pkg::*;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               group_last;
        logic               run_done;
    } digit_item_t;

    digit_item_t        owed_digits[$];
    logic [COUNT_W-1:0] digits_left;
    int                 fails;
    int                 matched;
    int                 taken;

    // Turns one accepted word into the digits it must produce and updates the run state.
    function automatic void predict_digits(input logic [WORD_W-1:0] word);
        logic [WIDE_W-1:0]  val;
        logic [WIDE_W-1:0]  scale;
        logic [DIGIT_W-1:0] digs [9];
        digit_item_t        item;
        int                 len;
        int                 i;
        if (digits_left == '0 || word >= REJECT_LIMIT)
            return;
        val = {2'b00, word} % GROUP_MODULUS;
        len = (digits_left >= GROUP_DIGITS) ? 9 : int'(digits_left);
        scale = 1;
        for (i = 0; i < len; i++)
            scale = scale * 10;
        val = val % scale;
        digits_left = digits_left - COUNT_W'(len);
        for (i = len - 1; i >= 0; i--)
        begin
            digs[i] = DIGIT_W'(val % 10);
            val = val / 10;
        end
        for (i = 0; i < len; i++)
        begin
            item.digit      = digs[i];
            item.group_last = (i == len - 1);
            item.run_done   = (i == len - 1) && (digits_left == '0);
            owed_digits.push_back(item);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digit_item_t want;
        if (!rst_n)
        begin
            digits_left = COUNT_RESET;
            owed_digits.delete();
            fails   = 0;
            matched = 0;
            taken   = 0;
        end
        else
        begin
            // Writes must only come while the block is idle (unenforced); stream order is moot.
            if (cfg_valid && cfg_ready)
                digits_left = cfg_data;
            if (s_tvalid && s_tready)
            begin
                taken++;
                predict_digits(s_tdata);
            end
            if (m_tvalid && m_tready)
            begin
                if (owed_digits.size() == 0)
                begin
                    $error("digit: no transfer expected, got tdata %0h tlast %0b tuser %0b",
                           m_tdata, m_tlast, m_tuser);
                    fails++;
                end
                else
                begin
                    want = owed_digits.pop_front();
                    if (m_tdata !== {4'b0000, want.digit})
                    begin
                        $error("digit: expected %0d, got %0d", want.digit, m_tdata);
                        fails++;
                    end
                    if (m_tlast !== want.group_last)
                    begin
                        $error("group_last: expected %0b, got %0b", want.group_last, m_tlast);
                        fails++;
                    end
                    if (m_tuser !== want.run_done)
                    begin
                        $error("run_done: expected %0b, got %0b", want.run_done, m_tuser);
                        fails++;
                    end
                    matched++;
                end
            end
        end
        // Outputs are assigned nonblocking so readers in other processes never race the update.
        fail_count     <= fails;
        digits_owed    <= owed_digits.size();
        run_left       <= digits_left;
        digits_matched <= matched;
        words_taken    <= taken;
    end

endmodule

FILE: tb/sv/tb_random_word_to_decimal_digits.sv
// Top of the testbench for the random word to decimal digits block: stimulus and verdict.
`timescale 1ns / 1ps

module tb_random_word_to_decimal_digits;

    import rwdd_pkg::*;

    // Counted random words per idling phase. With the directed words and the extra words
    // that probe each finished run, the whole run sends about 260 words.
    localparam int PHASE_WORDS  = 70;
    // A word takes ten steps of the block; a little margin on top of that.
    localparam int DRAIN_CYCLES = 14;
    // Length of the one long output hold-off that backs the block up to its input.
    localparam int HOLD_CYCLES  = 150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RUN_WORDS    = 40;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [19:0] cfg_data  = '0;

    int                 fail_count;
    int                 digits_owed;
    logic [COUNT_W-1:0] run_left;
    int                 digits_matched;
    int                 words_taken;

    // Idling odds in percent, set per phase by the stimulus process.
    int send_idle_pct = 29;
    int recv_idle_pct = 69;
    int phase         = 0;
    int words_sent    = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int cycles        = 0;
    int counts_loaded = 0;

    always #10 clk = ~clk;

    random_word_to_decimal_digits u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    rwdd_digit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .digits_owed    (digits_owed),
        .run_left       (run_left),
        .digits_matched (digits_matched),
        .words_taken    (words_taken)
    );

    // Watchdog: a hung handshake or a digit that never comes ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_random_word_to_decimal_digits: done, errors");
            $finish;
        end
    end

    // Digit receiver. It stalls at random with the odds of the current phase. Once, early in
    // the first random phase, it holds off for a long stretch so the block's output register
    // stays full, the step unit stops and s_tready falls while the sender keeps offering words.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else if (hold_left != 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (!hold_done && phase == 0 && words_sent >= 30)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offers one word and returns after the first edge past which s_tready reads high. tvalid
    // stays high across back to back transfers; the next call lowers it only if it idles.
    task automatic send_word(input logic [31:0] word);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stops offering words and waits until every predicted digit has been taken, then lets
    // the block run out its step sequence. The first edge lets the checker count the last word.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (digits_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the digit count; only called once the block has settled.
    task automatic load_count(input logic [19:0] count);
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        counts_loaded++;
    endtask

    // Mostly accepted words, with rejected words, the region around the limit and multiples
    // of one billion mixed in.
    function automatic logic [31:0] pick_word();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return $urandom_range(32'hFFFF_FFFF, 32'd4000000000);
        if (pick < 14)
            return $urandom;
        if (pick < 17)
            return $urandom_range(32'd4000000005, 32'd3999999990);
        if (pick < 20)
            return 32'd1000000000 * $urandom_range(0, 3) + $urandom_range(0, 2);
        return $urandom_range(0, 32'd3999999999);
    endfunction

    // Digit counts: short runs mostly, a zero count, exactly nine, and values at and above
    // the top of the useful range that do not finish within one run of words.
    function automatic logic [19:0] pick_count();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 6)
            return '0;
        if (pick < 14)
            return 20'd9;
        if (pick < 17)
            return 20'hFFFFF;
        if (pick < 20)
            return 20'(589823 - $urandom_range(0, 3));
        return 20'($urandom_range(1, 45));
    endfunction

    initial
    begin
        int n;
        int target;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The reset count of ten allows one full group and one digit.
        send_word(32'd4000000000);   // lowest rejected word
        send_word(32'hFFFF_FFFF);    // highest rejected word
        send_word(32'd3999999999);   // highest accepted word: nine nines
        send_word(32'hF000_0000);    // rejected, state must not move
        send_word(32'd1234567890);   // one digit left: only the lowest digit, run ends
        send_word(32'd0);            // run finished, nothing comes out
        send_word(32'h1234_5678);
        settle();

        // A zero count ends the run at once.
        load_count('0);
        send_word(32'd0);
        send_word(32'd999);
        settle();

        // Exactly nine: the last digit of the group also ends the run.
        load_count(20'd9);
        send_word(32'd987654321);
        send_word(32'd5);
        settle();

        // A short tail: eight digits from a word whose top digit must be dropped.
        load_count(20'd17);
        send_word(32'd123456789);
        send_word(32'd3000000001);
        settle();

        load_count(20'd1);
        send_word(32'd1000000009);
        settle();

        // Count with every bit set, beyond any sensible request; taken as given.
        load_count(20'hFFFFF);
        send_word(32'd999999999);
        send_word(32'd1000000000);
        send_word(32'd2999999999);
        send_word(32'h5555_5555);
        send_word(32'hAAAA_AAAA);
        settle();

        // Random part in three idling phases: slow receiver, then slow sender, then no idling.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 29; recv_idle_pct = 69; end
                1:       begin send_idle_pct = 69; recv_idle_pct = 29; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
            begin
                load_count(pick_count());
                n = 0;
                while (n < RUN_WORDS && words_sent < target)
                begin
                    // Once the run is over, one more word checks that it is ignored.
                    if (run_left == '0)
                    begin
                        send_word(pick_word());
                        break;
                    end
                    send_word(pick_word());
                    n++;
                    words_sent++;
                end
                settle();
            end
        end

        settle();
        $display("Covered %0d words (%0d random) over %0d digit counts and three idling phases,",
                 words_taken, words_sent, counts_loaded);
        $display("with one long output hold-off; %0d digits checked, %0d mismatches.",
                 digits_matched, fail_count);
        if (fail_count == 0)
            $display("tb_random_word_to_decimal_digits: done, clean");
        else
            $display("tb_random_word_to_decimal_digits: done, errors");
        $finish;
    end

endmodule
